[design/graph_edit_distance_by_permutation_core_defines.svh]
// ----------------------------------------------------------------------------
// Graph edit distance core assertion macros
// Property macros shared by the checker of the permutation search core.
// ----------------------------------------------------------------------------
`ifndef GRAPH_EDIT_DISTANCE_BY_PERMUTATION_CORE_DEFINES_SVH
`define GRAPH_EDIT_DISTANCE_BY_PERMUTATION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define GED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ged_chk: property violated");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define GED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ged_chk: property violated");

`endif

[design/ged_pkg.sv]
// ----------------------------------------------------------------------------
// Graph edit distance package
// Sizes, types and codes shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package ged_pkg;

  localparam int MAX_NODES = 8;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int ACC_W     = 16 + 2 * IDX_W;
  localparam int PROD_W    = ACC_W + 8 + 1;
  localparam int SUM_W     = (PROD_W > 32) ? PROD_W : 33;

  typedef logic [MAX_NODES-1:0][IDX_W-1:0] perm_t;

  typedef enum logic [2:0] {
    REG_A_SIZE     = 3'd0,
    REG_B_SIZE     = 3'd1,
    REG_ITER_LIMIT = 3'd2,
    REG_EDGE_WT    = 3'd3,
    REG_RELABEL    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_EVAL,
    ST_DRAIN,
    ST_TOTAL,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic total;
    logic update;
    logic advance;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last_pair;
    logic iter_done;
    logic perm_wrap;
    logic out_free;
  } sts_t;

endpackage

[design/ged_ctrl.sv]
// ----------------------------------------------------------------------------
// Graph edit distance controller
// Sequences entry loading, the per-permutation cost walk and result hand-off.
// ----------------------------------------------------------------------------
module ged_ctrl import ged_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last_entry,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && in_last_entry) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.issue = 1'b1;
        if (sts.last_pair) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd.total = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.iter_done || sts.perm_wrap) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/ged_dp.sv]
// ----------------------------------------------------------------------------
// Graph edit distance datapath
// Matrix stores, permutation register, cost accumulator and result register.
// ----------------------------------------------------------------------------
module ged_dp import ged_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_row,
  input  logic [2:0]  in_col,
  input  logic [15:0] in_a_value,
  input  logic [15:0] in_b_value,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        cfg_ready,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [31:0] out_distance
);

  logic [3:0]  a_size_r, b_size_r;
  logic [15:0] iter_limit_r;
  logic [7:0]  edge_wt_r, relabel_r;

  logic [CNT_W-1:0] an_r, bn_r, n_r, an_nxt, bn_nxt;
  logic [IDX_W-1:0] i_r, j_r, nm1;
  perm_t            perm_r, perm_adv, perm_swp;
  logic [IDX_W-1:0] piv, pv, sw;
  logic             found;
  logic [15:0]      iter_r;

  logic [15:0] mem_a [MEM_DEPTH];
  logic [15:0] mem_b [MEM_DEPTH];
  logic [15:0] a_rd_r, b_rd_r;
  logic        a_out_r, b_out_r, vld1_r;
  logic        wr_ok;
  logic [ADDR_W-1:0] wr_addr, rd_a_addr, rd_b_addr;

  logic [15:0]      x_val, y_val, abs_d;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] moved;
  logic [PROD_W-1:0] wt_prod;
  logic [CNT_W+7:0] rl_prod;
  logic [SUM_W-1:0] sum;
  logic [31:0]      total_r, best_r;
  logic             best_valid_r;
  logic             out_valid_r;
  logic [31:0]      out_dist_r;

  function automatic logic [CNT_W-1:0] clamp_size(input logic [3:0] s);
    logic [CNT_W-1:0] c;
    if (s == 4'd0) begin
      c = CNT_W'(1);
    end else if (int'(s) > MAX_NODES) begin
      c = CNT_W'(MAX_NODES);
    end else begin
      c = CNT_W'(s);
    end
    return c;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_size_r     <= 4'd8;
      b_size_r     <= 4'd8;
      iter_limit_r <= 16'd300;
      edge_wt_r    <= 8'd1;
      relabel_r    <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_A_SIZE:     a_size_r     <= cfg_data[3:0];
        REG_B_SIZE:     b_size_r     <= cfg_data[3:0];
        REG_ITER_LIMIT: iter_limit_r <= cfg_data;
        REG_EDGE_WT:    edge_wt_r    <= cfg_data[7:0];
        REG_RELABEL:    relabel_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign an_nxt = clamp_size(a_size_r);
  assign bn_nxt = clamp_size(b_size_r);

  // Entry store and registered reads.
  assign wr_ok     = (int'(in_row) < MAX_NODES) && (int'(in_col) < MAX_NODES);
  assign wr_addr   = {IDX_W'(in_row), IDX_W'(in_col)};
  assign rd_a_addr = {perm_r[i_r], perm_r[j_r]};
  assign rd_b_addr = {i_r, j_r};

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      mem_a[wr_addr] <= in_a_value;
      mem_b[wr_addr] <= in_b_value;
    end
    if (cmd.issue) begin
      a_rd_r  <= mem_a[rd_a_addr];
      b_rd_r  <= mem_b[rd_b_addr];
      a_out_r <= (CNT_W'(perm_r[i_r]) >= an_r) || (CNT_W'(perm_r[j_r]) >= an_r);
      b_out_r <= (CNT_W'(i_r) >= bn_r) || (CNT_W'(j_r) >= bn_r);
    end
  end

  // Sizes, walk counters and iteration budget.
  assign nm1 = IDX_W'(n_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      an_r   <= '0;
      bn_r   <= '0;
      n_r    <= '0;
      i_r    <= '0;
      j_r    <= '0;
      iter_r <= '0;
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= cmd.issue;
      if (cmd.start) begin
        an_r   <= an_nxt;
        bn_r   <= bn_nxt;
        n_r    <= (an_nxt > bn_nxt) ? an_nxt : bn_nxt;
        iter_r <= (iter_limit_r == 16'd0) ? 16'd1 : iter_limit_r;
      end else if (cmd.update) begin
        iter_r <= iter_r - 16'd1;
      end
      if (cmd.start || cmd.advance) begin
        i_r <= '0;
        j_r <= '0;
      end else if (cmd.issue) begin
        if (j_r == nm1) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
    end
  end

  // Lexicographic successor of the current permutation over n entries.
  always_comb begin
    piv   = '0;
    found = 1'b0;
    for (int k = 1; k < MAX_NODES; k++) begin
      if (k < int'(n_r) && perm_r[k-1] < perm_r[k]) begin
        piv   = IDX_W'(k);
        found = 1'b1;
      end
    end
    pv = piv - 1'b1;
    sw = '0;
    for (int k = 0; k < MAX_NODES; k++) begin
      if (k < int'(n_r) && k > int'(pv) && perm_r[k] > perm_r[pv]) begin
        sw = IDX_W'(k);
      end
    end
    perm_swp     = perm_r;
    perm_swp[pv] = perm_r[sw];
    perm_swp[sw] = perm_r[pv];
    perm_adv     = perm_swp;
    for (int k = 0; k < MAX_NODES; k++) begin
      if (k >= int'(piv) && k < int'(n_r)) begin
        perm_adv[k] = perm_swp[IDX_W'(int'(piv) + int'(n_r) - 1 - k)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      for (int k = 0; k < MAX_NODES; k++) begin
        perm_r[k] <= IDX_W'(k);
      end
    end else if (cmd.advance) begin
      perm_r <= perm_adv;
    end
  end

  // Absolute difference accumulation.
  assign x_val = a_out_r ? 16'd0 : a_rd_r;
  assign y_val = b_out_r ? 16'd0 : b_rd_r;
  assign abs_d = (x_val > y_val) ? (x_val - y_val) : (y_val - x_val);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.start || cmd.advance) begin
      acc_nxt = '0;
    end else if (vld1_r) begin
      acc_nxt = acc_r + ACC_W'(abs_d);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Weighted total, saturated to 32 bits.
  always_comb begin
    moved = '0;
    for (int k = 0; k < MAX_NODES; k++) begin
      if (k < int'(n_r) && int'(perm_r[k]) != k) begin
        moved = moved + 1'b1;
      end
    end
  end

  assign wt_prod = PROD_W'(acc_r) * PROD_W'(edge_wt_r);
  assign rl_prod = (CNT_W+8)'(moved) * (CNT_W+8)'(relabel_r);
  assign sum     = SUM_W'(wt_prod) + SUM_W'(rl_prod);

  always_ff @(posedge clk) begin
    if (cmd.total) begin
      total_r <= (|sum[SUM_W-1:32]) ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      best_valid_r <= 1'b0;
      best_r       <= '0;
    end else if (cmd.update) begin
      best_valid_r <= 1'b1;
      if (!best_valid_r || total_r < best_r) begin
        best_r <= total_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.publish) begin
      out_dist_r <= best_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;

  assign sts.last_pair = (i_r == nm1) && (j_r == nm1);
  assign sts.iter_done = (iter_r == 16'd1);
  assign sts.perm_wrap = !found;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

[design/graph_edit_distance_by_permutation_core.sv]
// ----------------------------------------------------------------------------
// Graph edit distance by permutation search, top level
// Entries load one per cycle while idle (in_stall low); the last entry starts a search
// of up to the iteration limit of permutations (n*n reads each), ending if they wrap.
// Synchronous active-low reset restores register defaults; stores are unset.
// ----------------------------------------------------------------------------
module graph_edit_distance_by_permutation_core import ged_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_row,
  input  logic [2:0]  in_col,
  input  logic [15:0] in_a_value,
  input  logic [15:0] in_b_value,
  input  logic        in_last_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_distance,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  ged_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_entry (in_last_entry),
    .sts           (sts),
    .in_stall      (in_stall),
    .cmd           (cmd)
  );

  ged_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_a_value   (in_a_value),
    .in_b_value   (in_b_value),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg_ready    (cfg_ready),
    .cmd          (cmd),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_distance (out_distance)
  );

endmodule

[design/ged_chk.sv]
// ----------------------------------------------------------------------------
// Graph edit distance port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
`include "graph_edit_distance_by_permutation_core_defines.svh"

module ged_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_row,
  input logic [2:0]  in_col,
  input logic [15:0] in_a_value,
  input logic [15:0] in_b_value,
  input logic        in_last_entry,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_distance
);

  `GED_ASSERT_NXT(a_search_blocks_input, in_valid && !in_stall && in_last_entry, in_stall)
  `GED_ASSERT_NXT(a_load_keeps_input, in_valid && !in_stall && !in_last_entry, !in_stall)
  `GED_ASSERT_IMP(a_result_after_search, $rose(out_valid), $past(in_stall))
  `GED_ASSERT_NXT(a_result_holds, out_valid && out_stall, out_valid && $stable(out_distance))
  `GED_ASSERT_NXT(a_input_holds, in_valid && in_stall, in_valid && $stable(in_row) && $stable(in_col) && $stable(in_a_value) && $stable(in_b_value) && $stable(in_last_entry))

endmodule

bind graph_edit_distance_by_permutation_core ged_chk u_ged_chk (.*);
